[hdl/rau_pkg.sv]
package rau_pkg;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] left_num;
        logic signed [31:0] left_den;
        logic signed [31:0] right_num;
        logic signed [31:0] right_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEQ,
        S_GCD,
        S_GSH,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

    typedef enum logic [4:0] {
        P_RED0,
        P_RED1,
        P_RED2,
        P_RED3,
        P_STORE_L,
        P_STORE_R,
        P_NEG,
        P_ADD0,
        P_ADD1,
        P_ADD2,
        P_ADD3A,
        P_ADD3,
        P_ADD4,
        P_ADD5,
        P_ADD6,
        P_M1,
        P_M2,
        P_FIN
    } t_step;

endpackage

[hdl/rational_arithmetic_unit.sv]
// Fraction add, subtract, multiply and divide with gcd reduction of both
// operands and of the result; the result denominator is positive. One item
// is worked at a time and the input is stalled until its result has been
// taken. All work runs through one shared unit that acts as a binary gcd,
// a restoring divider or a shift-add multiplier, under a step sequencer.
// A reduction is one gcd and two divisions. An item runs three reductions
// (four for subtract); add and subtract also need three multiplications
// and, unless the reduced denominators are equal, one more gcd and two
// divisions; multiply and divide need two multiplications. A zero operand
// denominator or a zero divisor ends the item early.
// Arithmetic wraps at DATA_WIDTH bits; inputs are sign-extended to it.
module rational_arithmetic_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rau_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rau_pkg::t_out_item  o_out_item
);
    import rau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);

    t_state r_state, n_state;
    t_step  r_pc, n_pc, r_ret;

    logic [1:0]   r_act;
    logic [W-1:0] r_ln, r_ld, r_rn, r_rd, r_tn, r_td;
    logic [W-1:0] r_g, r_f1, r_f2, r_p;
    logic [W-1:0] r_ua, r_ub, r_ur;
    logic [CW-1:0] r_cnt, r_k;
    logic signed [31:0] r_rin_num, r_rin_den;
    t_out_item    r_out;

    function automatic logic [W-1:0] absw(input logic [W-1:0] x);
        return x[W-1] ? (W'(0) - x) : x;
    endfunction

    function automatic logic [W-1:0] sgnw(input logic neg, input logic [W-1:0] x);
        return neg ? (W'(0) - x) : x;
    endfunction

    // shared unit step values
    logic [W:0]   w_rem;
    logic         w_qbit;
    logic [W-1:0] w_rnew, w_acc, w_dn;

    always_comb begin
        w_rem  = {r_ur, r_ua[W-1]};
        w_qbit = (w_rem >= {1'b0, r_ub});
        w_rnew = w_qbit ? W'(w_rem - {1'b0, r_ub}) : w_rem[W-1:0];
        w_acc  = r_ub[0] ? (r_ur + r_ua) : r_ur;
        w_dn   = sgnw(r_td[W-1], r_ua);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SEQ;
                    n_pc    = P_RED0;
                end
            end
            S_SEQ: begin
                unique case (r_pc)
                    P_RED0: begin
                        if (r_td == '0) begin
                            n_state = S_OUT;
                        end else begin
                            n_state = S_GCD;
                            n_pc    = P_RED1;
                        end
                    end
                    P_RED1: begin n_state = S_DIV; n_pc = P_RED2; end
                    P_RED2: begin n_state = S_DIV; n_pc = P_RED3; end
                    P_RED3: n_pc = r_ret;
                    P_STORE_L: n_pc = P_RED0;
                    P_STORE_R: begin
                        unique case (r_act)
                            ACT_ADD: n_pc = P_ADD0;
                            ACT_SUB: n_pc = P_RED0;
                            ACT_MUL: begin n_state = S_MUL; n_pc = P_M1; end
                            ACT_DIV: begin
                                if (r_tn == '0) begin
                                    n_state = S_OUT;
                                end else begin
                                    n_state = S_MUL;
                                    n_pc    = P_M1;
                                end
                            end
                            default: n_pc = P_ADD0;
                        endcase
                    end
                    P_NEG: n_pc = P_ADD0;
                    P_ADD0: begin
                        if (r_ld == r_rd) begin
                            n_pc = P_ADD3;
                        end else begin
                            n_state = S_GCD;
                            n_pc    = P_ADD1;
                        end
                    end
                    P_ADD1: begin n_state = S_DIV; n_pc = P_ADD2; end
                    P_ADD2: begin n_state = S_DIV; n_pc = P_ADD3A; end
                    P_ADD3A: n_pc = P_ADD3;
                    P_ADD3: begin n_state = S_MUL; n_pc = P_ADD4; end
                    P_ADD4: begin n_state = S_MUL; n_pc = P_ADD5; end
                    P_ADD5: begin n_state = S_MUL; n_pc = P_ADD6; end
                    P_ADD6: n_pc = P_RED0;
                    P_M1: begin n_state = S_MUL; n_pc = P_M2; end
                    P_M2: n_pc = P_RED0;
                    P_FIN: n_state = S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_GCD: begin
                if (r_ua == '0 || r_ub == '0) begin
                    n_state = S_GSH;
                end
            end
            S_GSH: begin
                if (r_k == '0) begin
                    n_state = S_SEQ;
                end
            end
            S_DIV, S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = S_SEQ;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_OUT);
        o_out_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= P_RED0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_act     <= i_in_item.action;
                    r_tn      <= W'(i_in_item.left_num);
                    r_td      <= W'(i_in_item.left_den);
                    r_rin_num <= i_in_item.right_num;
                    r_rin_den <= i_in_item.right_den;
                    r_ret     <= P_STORE_L;
                end
            end
            S_SEQ: begin
                case (r_pc)
                    P_RED0: begin
                        if (r_td == '0) begin
                            r_out <= '{result_num: '0, result_den: '0, status: ST_ZERO_DEN};
                        end else begin
                            r_ua <= absw(r_tn);
                            r_ub <= absw(r_td);
                            r_k  <= '0;
                        end
                    end
                    P_RED1: begin
                        r_g   <= r_ua;
                        r_ub  <= r_ua;
                        r_ua  <= absw(r_tn);
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_RED2: begin
                        r_tn  <= sgnw(r_tn[W-1], r_ua);
                        r_ua  <= absw(r_td);
                        r_ub  <= r_g;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_RED3: begin
                        // a negative denominator moves its sign to the numerator
                        if (w_dn[W-1]) begin
                            r_td <= W'(0) - w_dn;
                            r_tn <= W'(0) - r_tn;
                        end else begin
                            r_td <= w_dn;
                        end
                    end
                    P_STORE_L: begin
                        r_ln  <= r_tn;
                        r_ld  <= r_td;
                        r_tn  <= W'(r_rin_num);
                        r_td  <= W'(r_rin_den);
                        r_ret <= P_STORE_R;
                    end
                    P_STORE_R: begin
                        r_rn  <= r_tn;
                        r_rd  <= r_td;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                        r_ua  <= r_ln;
                        case (r_act)
                            ACT_SUB: begin
                                r_tn  <= W'(0) - r_tn;
                                r_ret <= P_NEG;
                            end
                            ACT_MUL: r_ub <= r_tn;
                            ACT_DIV: begin
                                r_ub  <= r_td;
                                if (r_tn == '0) begin
                                    r_out <= '{result_num: '0, result_den: '0,
                                               status: ST_DIV_ZERO};
                                end
                            end
                            default: r_ub <= r_tn;
                        endcase
                    end
                    P_NEG: begin
                        r_rn <= r_tn;
                        r_rd <= r_td;
                    end
                    P_ADD0: begin
                        r_f1 <= W'(1);
                        r_f2 <= W'(1);
                        r_ua <= absw(r_ld);
                        r_ub <= absw(r_rd);
                        r_k  <= '0;
                    end
                    P_ADD1: begin
                        r_g   <= (r_ua == '0) ? W'(1) : r_ua;
                        r_ub  <= (r_ua == '0) ? W'(1) : r_ua;
                        r_ua  <= absw(r_rd);
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_ADD2: begin
                        r_f1  <= sgnw(r_rd[W-1], r_ua);
                        r_ua  <= absw(r_ld);
                        r_ub  <= r_g;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_ADD3A: r_f2 <= sgnw(r_ld[W-1], r_ua);
                    P_ADD3: begin
                        r_ua  <= r_ln;
                        r_ub  <= r_f1;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_ADD4: begin
                        r_p   <= r_ua;
                        r_ua  <= r_rn;
                        r_ub  <= r_f2;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_ADD5: begin
                        r_tn  <= r_p + r_ua;
                        r_ua  <= r_ld;
                        r_ub  <= r_f1;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_ADD6: begin
                        r_td  <= r_ua;
                        r_ret <= P_FIN;
                    end
                    P_M1: begin
                        r_tn  <= r_ua;
                        r_ua  <= r_ld;
                        r_ub  <= (r_act == ACT_DIV) ? r_rn : r_rd;
                        r_ur  <= '0;
                        r_cnt <= CW'(W - 1);
                    end
                    P_M2: begin
                        r_td  <= r_ua;
                        r_ret <= P_FIN;
                    end
                    P_FIN: begin
                        r_out <= '{result_num: 32'($signed(r_tn)),
                                   result_den: 31'($signed(r_td)),
                                   status: ST_OK};
                    end
                    default: ;
                endcase
            end
            S_GCD: begin
                // binary gcd, common factors of two counted in r_k
                if (r_ua == '0) begin
                    r_ua <= r_ub;
                end else if (r_ub != '0) begin
                    if (!r_ua[0] && !r_ub[0]) begin
                        r_ua <= r_ua >> 1;
                        r_ub <= r_ub >> 1;
                        r_k  <= r_k + CW'(1);
                    end else if (!r_ua[0]) begin
                        r_ua <= r_ua >> 1;
                    end else if (!r_ub[0]) begin
                        r_ub <= r_ub >> 1;
                    end else if (r_ua >= r_ub) begin
                        r_ua <= r_ua - r_ub;
                    end else begin
                        r_ub <= r_ub - r_ua;
                    end
                end
            end
            S_GSH: begin
                if (r_k != '0) begin
                    r_ua <= r_ua << 1;
                    r_k  <= r_k - CW'(1);
                end
            end
            S_DIV: begin
                r_ur  <= w_rnew;
                r_ua  <= {r_ua[W-2:0], w_qbit};
                r_cnt <= r_cnt - CW'(1);
            end
            S_MUL: begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_ua <= w_acc;
                end else begin
                    r_ur <= w_acc;
                    r_ua <= r_ua << 1;
                    r_ub <= r_ub >> 1;
                end
            end
            default: ;
        endcase
    end

endmodule
